// ===== sv/png_rf_pkg.sv =====
// Shared types, constants and the Paeth predictor for the PNG row filter.
package png_rf_pkg;

   localparam int DEF_MAX_ROW_BYTES = 8192;
   localparam int DEF_MAX_BPP       = 4;

   localparam int PIX_W       = 8;
   localparam int MODE_W      = 3;
   localparam int BPP_W       = 3;
   localparam int ROW_BYTES_W = 14;
   localparam int COST_W      = 21;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 14;
   localparam int RSP_DATA_W  = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_NONE       = 3'd0,
      MODE_SUB        = 3'd1,
      MODE_UP         = 3'd2,
      MODE_AVG        = 3'd3,
      MODE_PAETH      = 3'd4,
      MODE_FIRST_AVG  = 3'd5,
      MODE_FIRST_PAETH = 3'd6
   } filter_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_MODE = 2'd0,
      CSR_BPP         = 2'd1,
      CSR_ROW_BYTES   = 2'd2
   } csr_index_type;

   // Paeth predictor: pick the neighbor closest to a + b - c, ties to a, then b.
   function automatic logic [PIX_W-1:0] paeth_pick(input logic [PIX_W-1:0] a,
                                                   input logic [PIX_W-1:0] b,
                                                   input logic [PIX_W-1:0] c);
      logic signed [PIX_W+2:0] sa, sb, sc;
      logic signed [PIX_W+2:0] da, db, dc;
      logic [PIX_W+1:0] pa, pb, pc;
      logic [PIX_W-1:0] pick;
      sa = $signed({3'b000, a});
      sb = $signed({3'b000, b});
      sc = $signed({3'b000, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - sc - sc;
      pa = da[PIX_W+2] ? (PIX_W+2)'(-da) : (PIX_W+2)'(da);
      pb = db[PIX_W+2] ? (PIX_W+2)'(-db) : (PIX_W+2)'(db);
      pc = dc[PIX_W+2] ? (PIX_W+2)'(-dc) : (PIX_W+2)'(dc);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

// ===== sv/png_rf_line_buf.sv =====
// Previous-row line buffer: one write and one registered read per cycle, with bypass.
module png_rf_line_buf #(
   parameter int DEPTH  = png_rf_pkg::DEF_MAX_ROW_BYTES,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [ADDR_W-1:0]             wr_addr,
   input  logic [png_rf_pkg::PIX_W-1:0]  wr_data,
   input  logic [ADDR_W-1:0]             rd_addr,
   output logic [png_rf_pkg::PIX_W-1:0]  rd_data
);
   import png_rf_pkg::*;

   logic [PIX_W-1:0] mem [DEPTH];
   logic [PIX_W-1:0] rd_ff;
   logic             byp_ff;
   logic             byp_in;
   logic [PIX_W-1:0] byp_data_ff;

   // Read returns the old word; forward the write when both hit one address.
   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff       <= mem[rd_addr];
      byp_data_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

// ===== sv/png_rf_predict.sv =====
// Predictor select and filtered-byte magnitude for one raw byte.
module png_rf_predict (
   input  logic [png_rf_pkg::MODE_W-1:0] mode,
   input  logic [png_rf_pkg::PIX_W-1:0]  raw,
   input  logic [png_rf_pkg::PIX_W-1:0]  left,
   input  logic [png_rf_pkg::PIX_W-1:0]  up,
   input  logic [png_rf_pkg::PIX_W-1:0]  upleft,
   output logic signed [png_rf_pkg::PIX_W-1:0] diff,
   output logic [png_rf_pkg::PIX_W-1:0]  mag
);
   import png_rf_pkg::*;

   logic [PIX_W-1:0] pred;
   logic [PIX_W:0]   avg_sum;
   logic [PIX_W-1:0] diff_u;

   assign avg_sum = {1'b0, left} + {1'b0, up};

   always_comb begin
      unique case (filter_mode_type'(mode))
         MODE_SUB:         pred = left;
         MODE_UP:          pred = up;
         MODE_AVG:         pred = avg_sum[PIX_W:1];
         MODE_PAETH:       pred = paeth_pick(left, up, upleft);
         MODE_FIRST_AVG:   pred = {1'b0, left[PIX_W-1:1]};
         MODE_FIRST_PAETH: pred = paeth_pick(left, '0, '0);
         default:          pred = '0;
      endcase
   end

   assign diff_u = raw - pred;
   assign diff   = $signed(diff_u);
   // Absolute value of the signed byte; -128 maps to 128, which still fits.
   assign mag    = diff_u[PIX_W-1] ? (~diff_u + PIX_W'(1)) : diff_u;

endmodule

// ===== sv/png_row_filter_with_cost_sum.sv =====
// PNG row filter with per-row filter-choice cost: top level.
//
// Takes one raw image byte per transfer on req_ and returns one result per byte
// on rsp_: the filtered byte (raw minus the PNG predictor, mod 256, signed), the
// running sum of absolute filtered values in the current row and tlast on the
// last byte of each row. Throughput is one byte per clock while rsp_ is not stalled:
// the predictor, the cost add and the row bookkeeping sit between the state
// registers and a single result register, and the previous-row byte comes from
// a line buffer with one write port and one registered read port. The buffer is
// read one byte ahead (the next column is fetched while the current byte is
// written), so back-to-back bytes never wait on it. A new byte is taken whenever
// the result register is empty or being drained in the same cycle. Up, average
// and Paeth (modes 2 to 4) need one complete row written first; modes 5 and 6
// are their first-row forms. Register writes on csr_ apply from the next byte
// and do not restart the row; a lowered row length ends the row at once when
// the column already reaches it. The line buffer needs no clearing after reset.
module png_row_filter_with_cost_sum #(
   parameter int MAX_ROW_BYTES       = png_rf_pkg::DEF_MAX_ROW_BYTES,
   parameter int MAX_BYTES_PER_PIXEL = png_rf_pkg::DEF_MAX_BPP
) (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: [7:0] pixel_byte
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [png_rf_pkg::PIX_W-1:0]       req_tdata,
   // rsp_tdata: [7:0] filtered_byte, [28:8] row_cost, [31:29] zero
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [png_rf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                               rsp_tlast,
   input  logic                               csr_we,
   input  logic [png_rf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [png_rf_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import png_rf_pkg::*;

   localparam int COL_W  = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
   localparam int CMP_W  = (COL_W + 1 > ROW_BYTES_W) ? COL_W + 1 : ROW_BYTES_W;
   localparam int HIST_W = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
   localparam int PAD_W  = RSP_DATA_W - COST_W - PIX_W;

   // Configuration registers.
   logic [MODE_W-1:0]      mode_ff;
   logic [BPP_W-1:0]       bpp_ff;
   logic [ROW_BYTES_W-1:0] len_ff;

   // Row state.
   logic [COL_W-1:0]  col_ff;
   logic [COL_W-1:0]  col_in;
   logic [COST_W-1:0] cost_ff;
   logic [COST_W-1:0] cost_in;
   logic [PIX_W-1:0]  left_ff   [MAX_BYTES_PER_PIXEL];
   logic [PIX_W-1:0]  upleft_ff [MAX_BYTES_PER_PIXEL];

   // Result register.
   logic                     out_valid_ff;
   logic signed [PIX_W-1:0]  out_byte_ff;
   logic [COST_W-1:0]        out_cost_ff;
   logic                     out_last_ff;

   logic              req_fire;
   logic [3:0]        bpp_clamp;
   logic [HIST_W-1:0] hist_idx;
   logic [CMP_W-1:0]  len_eff;
   logic [CMP_W-1:0]  col_next_full;
   logic              row_last;
   logic [COL_W-1:0]  rd_addr;
   logic [PIX_W-1:0]  up_byte;
   logic signed [PIX_W-1:0] diff;
   logic [PIX_W-1:0]  mag;

   // Accept whenever the result register is free or empties this cycle.
   assign req_tready = !out_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   // Clamp bytes per pixel to 1..MAX and pick the matching history tap.
   always_comb begin
      if (bpp_ff == '0) begin
         bpp_clamp = 4'd1;
      end else if ({1'b0, bpp_ff} > 4'(MAX_BYTES_PER_PIXEL)) begin
         bpp_clamp = 4'(MAX_BYTES_PER_PIXEL);
      end else begin
         bpp_clamp = {1'b0, bpp_ff};
      end
   end
   assign hist_idx = HIST_W'(bpp_clamp - 4'd1);

   // Clamp row length to 1..MAX and detect the row's last byte.
   always_comb begin
      if (len_ff == '0) begin
         len_eff = CMP_W'(1);
      end else if (CMP_W'(len_ff) > CMP_W'(MAX_ROW_BYTES)) begin
         len_eff = CMP_W'(MAX_ROW_BYTES);
      end else begin
         len_eff = CMP_W'(len_ff);
      end
   end
   assign col_next_full = CMP_W'(col_ff) + CMP_W'(1);
   assign row_last      = (col_next_full >= len_eff);
   assign col_in        = row_last ? '0 : COL_W'(col_next_full);

   // Prefetch the next column while a byte is taken; otherwise hold the current one.
   assign rd_addr = req_fire ? col_in : col_ff;

   png_rf_line_buf #(
      .DEPTH  (MAX_ROW_BYTES),
      .ADDR_W (COL_W)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_fire),
      .wr_addr (col_ff),
      .wr_data (req_tdata),
      .rd_addr (rd_addr),
      .rd_data (up_byte)
   );

   png_rf_predict u_predict (
      .mode   (mode_ff),
      .raw    (req_tdata),
      .left   (left_ff[hist_idx]),
      .up     (up_byte),
      .upleft (upleft_ff[hist_idx]),
      .diff   (diff),
      .mag    (mag)
   );

   assign cost_in = cost_ff + COST_W'(mag);

   // Configuration writes; unknown indexes drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NONE;
         bpp_ff  <= BPP_W'(3);
         len_ff  <= ROW_BYTES_W'(1024);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FILTER_MODE: mode_ff <= csr_wdata[MODE_W-1:0];
            CSR_BPP:         bpp_ff  <= csr_wdata[BPP_W-1:0];
            CSR_ROW_BYTES:   len_ff  <= csr_wdata[ROW_BYTES_W-1:0];
            default:         ;
         endcase
      end
   end

   // Row state: advance the column, shift the neighbor histories, clear at row end.
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         cost_ff <= '0;
         for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
            left_ff[i]   <= '0;
            upleft_ff[i] <= '0;
         end
      end else if (req_fire) begin
         col_ff <= col_in;
         if (row_last) begin
            cost_ff <= '0;
            for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
               left_ff[i]   <= '0;
               upleft_ff[i] <= '0;
            end
         end else begin
            cost_ff <= cost_in;
            for (int i = MAX_BYTES_PER_PIXEL - 1; i > 0; i--) begin
               left_ff[i]   <= left_ff[i-1];
               upleft_ff[i] <= upleft_ff[i-1];
            end
            left_ff[0]   <= req_tdata;
            upleft_ff[0] <= up_byte;
         end
      end
   end

   // Result register: load on a taken byte, drop once the transfer completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (req_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         out_byte_ff <= diff;
         out_cost_ff <= cost_in;
         out_last_ff <= row_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {PAD_W'(0), out_cost_ff, out_byte_ff};
   assign rsp_tlast  = out_last_ff;

   // A taken byte always lands in the result register.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> rsp_tvalid)
      else $error("taken byte did not produce a result");

   // The last byte of a row returns the column and cost to zero.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && row_last) |=> (col_ff == '0 && cost_ff == '0))
      else $error("row state not cleared at row end");

   // Inside a row the column steps by one per byte.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && !row_last) |=> (col_ff == COL_W'($past(col_ff) + 1'b1)))
      else $error("column did not advance by one");

   // The column never leaves the line buffer.
   assert property (@(posedge clock) disable iff (reset)
      (CMP_W'(col_ff) < CMP_W'(MAX_ROW_BYTES)))
      else $error("column beyond line buffer depth");

   // An empty result register must accept input.
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("input stalled with empty result register");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the PNG row filter with per-row cost sum.
`timescale 1ns / 1ps

module testbench;
   import png_rf_pkg::*;

   localparam int MAX_ROW = DEF_MAX_ROW_BYTES;
   localparam int MAX_BPP = DEF_MAX_BPP;
   // Columns of the line store filled by the first full row.
   localparam int FILL_COLS = 256;

   // Codes the package leaves unnamed: the spare filter mode and the spare
   // register index, both of which the block must tolerate.
   localparam logic [MODE_W-1:0]    MODE_UNUSED      = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // One expected transfer on the result channel.
   typedef struct packed {
      logic [PIX_W-1:0]  filtered;
      logic [COST_W-1:0] cost;
      logic              row_end;
   } filter_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PIX_W-1:0]        req_tdata = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   // Cycles left in a forced receiver hold-off; counted down by the receiver.
   int unsigned hold_off_cycles = 0;
   int unsigned fail_count = 0;

   // Predicted block state: register settings and filter history.
   logic [MODE_W-1:0]      mode_setting;
   logic [BPP_W-1:0]       bpp_setting;
   logic [ROW_BYTES_W-1:0] row_len_setting;
   logic [PIX_W-1:0]       above_row [MAX_ROW];
   bit                     above_written [MAX_ROW];
   logic [PIX_W-1:0]       left_bytes [MAX_BPP];
   logic [PIX_W-1:0]       upleft_bytes [MAX_BPP];
   int unsigned            column;
   logic [COST_W-1:0]      cost_sum;
   logic [PIX_W-1:0]       last_pixel = '0;

   filter_result_type expected_results [$];

   png_row_filter_with_cost_sum dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Paeth: the neighbor nearest to left + above - upper-left, ties to left,
   // then to above.
   function automatic logic [PIX_W-1:0] paeth_choice(input logic [PIX_W-1:0] a,
                                                     input logic [PIX_W-1:0] b,
                                                     input logic [PIX_W-1:0] c);
      int est, da, db, dc;
      est = int'(a) + int'(b) - int'(c);
      da = est - int'(a);
      db = est - int'(b);
      dc = est - int'(c);
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      if (dc < 0) dc = -dc;
      if (da <= db && da <= dc) return a;
      if (db <= dc) return b;
      return c;
   endfunction

   // Clear the per-row history; the line store keeps the previous row.
   function automatic void clear_row_history();
      for (int i = 0; i < MAX_BPP; i++) begin
         left_bytes[i] = '0;
         upleft_bytes[i] = '0;
      end
      column = 0;
      cost_sum = '0;
   endfunction

   function automatic void reset_prediction();
      mode_setting = MODE_NONE;
      bpp_setting = 3'd3;
      row_len_setting = 14'd1024;
      for (int i = 0; i < MAX_ROW; i++) begin
         above_row[i] = '0;
         above_written[i] = 1'b0;
      end
      clear_row_history();
   endfunction

   // Filter one accepted byte, advance the row state and queue the result.
   function automatic void filter_pixel(input logic [PIX_W-1:0] raw);
      int unsigned       bpp, len, col;
      logic [PIX_W-1:0]  a, b, c, pred, diff, mag;
      logic [PIX_W:0]    pair_sum;
      filter_result_type res;
      // Clamp the settings the way the block does.
      bpp = bpp_setting;
      if (bpp < 1) bpp = 1;
      if (bpp > MAX_BPP) bpp = MAX_BPP;
      len = row_len_setting;
      if (len < 1) len = 1;
      if (len > MAX_ROW) len = MAX_ROW;
      col = column;
      if (col >= MAX_ROW) col = MAX_ROW - 1;

      a = left_bytes[bpp-1];
      b = above_row[col];
      c = upleft_bytes[bpp-1];
      pair_sum = {1'b0, a} + {1'b0, b};

      case (mode_setting)
         MODE_SUB:         pred = a;
         MODE_UP:          pred = b;
         MODE_AVG:         pred = pair_sum[PIX_W:1];
         MODE_PAETH:       pred = paeth_choice(a, b, c);
         MODE_FIRST_AVG:   pred = a >> 1;
         MODE_FIRST_PAETH: pred = paeth_choice(a, '0, '0);
         default:          pred = '0;
      endcase

      diff = raw - pred;
      mag = diff[PIX_W-1] ? -diff : diff;
      cost_sum = cost_sum + COST_W'(mag);

      for (int i = MAX_BPP - 1; i > 0; i--) begin
         left_bytes[i] = left_bytes[i-1];
         upleft_bytes[i] = upleft_bytes[i-1];
      end
      left_bytes[0] = raw;
      upleft_bytes[0] = b;
      above_row[col] = raw;
      above_written[col] = 1'b1;

      res.filtered = diff;
      res.cost = cost_sum;
      res.row_end = (col + 1 >= len);
      expected_results.push_back(res);

      if (res.row_end) begin
         clear_row_history();
      end else begin
         column = col + 1;
      end
   endfunction

   // True when the next bytes would reach a line-store column that no byte
   // has written yet.
   function automatic bit burst_hits_unwritten(input int unsigned count);
      int unsigned len, col;
      len = row_len_setting;
      if (len < 1) len = 1;
      if (len > MAX_ROW) len = MAX_ROW;
      col = column;
      for (int i = 0; i < count; i++) begin
         if (!above_written[col]) return 1'b1;
         col = (col + 1 >= len) ? 0 : col + 1;
      end
      return 1'b0;
   endfunction

   // ------------------------------------------------------------------
   // Receiver and result check
   // ------------------------------------------------------------------

   // Stall at random, or hold off entirely while a forced stretch runs.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles = hold_off_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Compare every result transfer with the oldest prediction.
   always @(posedge clock) begin
      filter_result_type want;
      logic [PIX_W-1:0]  got_filtered;
      logic [COST_W-1:0] got_cost;
      logic [RSP_DATA_W-PIX_W-COST_W-1:0] got_pad;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_filtered = rsp_tdata[PIX_W-1:0];
         got_cost = rsp_tdata[PIX_W +: COST_W];
         got_pad = rsp_tdata[RSP_DATA_W-1:PIX_W+COST_W];
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: filtered_byte %0d row_cost %0d",
                   $signed(got_filtered), got_cost);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (got_filtered !== want.filtered) begin
               $error("filtered_byte mismatch: expected %0d, got %0d",
                      $signed(want.filtered), $signed(got_filtered));
               fail_count++;
            end
            if (got_cost !== want.cost) begin
               $error("row_cost mismatch: expected %0d, got %0d", want.cost, got_cost);
               fail_count++;
            end
            if (rsp_tlast !== want.row_end) begin
               $error("row_end mismatch: expected %0d, got %0d", want.row_end, rsp_tlast);
               fail_count++;
            end
            if (got_pad !== '0) begin
               $error("rsp_tdata padding mismatch: expected 0, got %0h", got_pad);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------

   // Offer one byte, idling first at the current rate; predict on transfer.
   // Valid stays high afterwards so that back-to-back bytes need no gap.
   task automatic send_pixel(input logic [PIX_W-1:0] value);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      do begin
         @(posedge clock);
      end while (!req_tready);
      filter_pixel(value);
      last_pixel = value;
   endtask

   // Drop valid and hold until every predicted result has been checked.
   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   // Write one register; the block must be idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (index)
         CSR_FILTER_MODE: mode_setting = value[MODE_W-1:0];
         CSR_BPP:         bpp_setting = value[BPP_W-1:0];
         CSR_ROW_BYTES:   row_len_setting = value[ROW_BYTES_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
   endtask

   // Mostly uniform bytes, some near the previous one so the Paeth choice
   // moves between neighbors, and some at the range ends.
   function automatic logic [PIX_W-1:0] next_pixel();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 65) return PIX_W'($urandom_range(255));
      if (pick < 90) return last_pixel + PIX_W'($urandom_range(8)) - PIX_W'(4);
      return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Run sub with the reset pixel width, then lower the row length mid-row:
   // the next byte must close the row. Finish with one full short row.
   task automatic test_reset_defaults();
      set_traffic(0, 0);
      write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_SUB));
      for (int i = 0; i < 10; i++) begin
         send_pixel(PIX_W'(i * 29 + 3));
      end
      wait_results_done();
      write_register(CSR_ROW_BYTES, 14'd4);
      send_pixel(8'hFF);
      send_pixel(8'h00);
      send_pixel(8'h7F);
      send_pixel(8'h80);
      send_pixel(8'h01);
      wait_results_done();
   endtask

   // One row of all 0x80 in mode none: every byte adds the largest magnitude.
   // It also fills the first columns of the line store for the up-based modes.
   task automatic test_full_row_cost();
      set_traffic(0, 0);
      write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_NONE));
      write_register(CSR_ROW_BYTES, CSR_DATA_W'(FILL_COLS));
      for (int i = 0; i < FILL_COLS; i++) begin
         send_pixel(8'h80);
      end
      wait_results_done();
   endtask

   // Every mode over short rows of extreme bytes, single-byte pixels.
   task automatic test_each_mode();
      logic [PIX_W-1:0] extremes [8] = '{8'h00, 8'hFF, 8'h80, 8'h7F,
                                         8'h01, 8'hFE, 8'h81, 8'h40};
      set_traffic(20, 20);
      write_register(CSR_ROW_BYTES, 14'd3);
      write_register(CSR_BPP, 14'd1);
      for (int m = MODE_NONE; m <= MODE_UNUSED; m++) begin
         write_register(CSR_FILTER_MODE, CSR_DATA_W'(m));
         for (int k = 0; k < 3; k++) begin
            send_pixel(extremes[(m + k * 3) % 8]);
         end
         wait_results_done();
      end
   endtask

   // Out-of-range and masked register values, and the spare index.
   task automatic test_register_extremes();
      set_traffic(0, 0);
      // Zero pixel width acts as one.
      write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_SUB));
      write_register(CSR_BPP, 14'd0);
      write_register(CSR_ROW_BYTES, 14'd4);
      send_pixel(8'h10); send_pixel(8'hF0); send_pixel(8'h7F); send_pixel(8'h80);
      wait_results_done();
      // Widest pixel width saturates to the largest supported.
      write_register(CSR_BPP, 14'h3FFF);
      write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_PAETH));
      write_register(CSR_ROW_BYTES, 14'd8192);
      for (int i = 0; i < 10; i++) begin
         send_pixel(next_pixel());
      end
      wait_results_done();
      // Zero row length acts as one: every byte closes its row.
      write_register(CSR_ROW_BYTES, 14'd0);
      write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_AVG));
      send_pixel(8'hFF); send_pixel(8'h00); send_pixel(8'h55);
      wait_results_done();
      // Upper data bits of the mode register are dropped; the spare index
      // changes nothing.
      write_register(CSR_ROW_BYTES, 14'd1);
      write_register(CSR_FILTER_MODE, 14'h3FF8 | CSR_DATA_W'(MODE_FIRST_AVG));
      write_register(CSR_UNUSED_INDEX, 14'h3FFF);
      write_register(CSR_ROW_BYTES, 14'd6);
      for (int i = 0; i < 6; i++) begin
         send_pixel(next_pixel());
      end
      wait_results_done();
   endtask

   // Hold the receiver off for a long stretch while bytes keep coming, so
   // the block fills and stalls its input.
   task automatic test_receiver_hold_off();
      set_traffic(0, 0);
      write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_PAETH));
      write_register(CSR_BPP, 14'd3);
      write_register(CSR_ROW_BYTES, 14'd17);
      hold_off_cycles = 200;
      for (int i = 0; i < 60; i++) begin
         send_pixel(next_pixel());
      end
      wait_results_done();
   endtask

   // Stop offering mid-row until everything has drained, then resume.
   task automatic test_sender_pause();
      set_traffic(0, 30);
      write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_AVG));
      write_register(CSR_ROW_BYTES, 14'd50);
      for (int i = 0; i < 30; i++) begin
         send_pixel(next_pixel());
      end
      wait_results_done();
      for (int i = 0; i < 30; i++) begin
         send_pixel(next_pixel());
      end
      wait_results_done();
   endtask

   // Random bursts, each after a random reconfiguration. Modes that read the
   // row above are swapped for a first-row form while the burst would reach
   // line-store columns not yet written.
   task automatic test_random_traffic(input int unsigned idle_pct,
                                      input int unsigned stall_pct,
                                      input int unsigned pixels);
      int unsigned sent, burst, pick;
      logic [CSR_DATA_W-1:0] length;
      set_traffic(idle_pct, stall_pct);
      sent = 0;
      while (sent < pixels) begin
         if ($urandom_range(1) != 0) begin
            write_register(CSR_FILTER_MODE, CSR_DATA_W'($urandom_range(16383)));
         end
         if ($urandom_range(2) == 0) begin
            write_register(CSR_BPP, CSR_DATA_W'($urandom_range(16383)));
         end
         if ($urandom_range(2) == 0) begin
            // Mostly short rows, a few long or out of range.
            pick = $urandom_range(99);
            if (pick < 5) length = '0;
            else if (pick < 80) length = CSR_DATA_W'($urandom_range(24, 1));
            else if (pick < 96) length = CSR_DATA_W'($urandom_range(300, 25));
            else length = CSR_DATA_W'($urandom_range(16383));
            write_register(CSR_ROW_BYTES, length);
         end
         burst = $urandom_range(40, 1);
         if ((mode_setting inside {MODE_UP, MODE_AVG, MODE_PAETH}) &&
             burst_hits_unwritten(burst)) begin
            if ($urandom_range(1) != 0) begin
               write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_FIRST_AVG));
            end else begin
               write_register(CSR_FILTER_MODE, CSR_DATA_W'(MODE_FIRST_PAETH));
            end
         end
         for (int i = 0; i < burst; i++) begin
            send_pixel(next_pixel());
         end
         sent += burst;
         wait_results_done();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      reset_prediction();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_full_row_cost();
      test_each_mode();
      test_register_extremes();
      test_receiver_hold_off();
      test_sender_pause();
      test_random_traffic(0, 0, 100);
      test_random_traffic(83, 0, 100);
      test_random_traffic(0, 83, 100);
      test_random_traffic(28, 28, 100);

      wait_results_done();
      repeat (5) @(posedge clock);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Stop a hung run; far beyond the slowest correct one.
   initial begin
      #5ms;
      $display("Verification failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/png_rf_pkg.sv
sv/png_rf_line_buf.sv
sv/png_rf_predict.sv
sv/png_row_filter_with_cost_sum.sv
tb/testbench.sv
